// File: rtl/tss_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler package
// Shared constants, register indexes and the types passed between modules.
// ---------------------------------------------------------------------------
package tss_pkg;

   localparam int SLOT_COUNT    = 63;
   localparam int ANTENNA_COUNT = 6;

   localparam int SLOT_W   = 6;
   localparam int TICK_W   = 12;
   localparam int ROLE_W   = 3;
   localparam int MASK_W   = 5;
   localparam int ROT_W    = 3;
   localparam int NODE_W   = 3;
   localparam int DIGIT_W  = 4;
   localparam int COUNT_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ROLE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_MASK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_SLOT_US = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_SLOT_US  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD_SLOT_US = 3'd5;

   localparam logic [TICK_W-1:0] SHORT_SLOT_RESET = 12'd800;
   localparam logic [TICK_W-1:0] LONG_SLOT_RESET  = 12'd2600;
   localparam logic [TICK_W-1:0] GUARD_SLOT_RESET = 12'd4000;

   localparam logic [ROLE_W-1:0] ROLE_MASTER = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_SLAVE1 = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_SLAVE2 = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_SLAVE3 = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_SLAVE4 = 3'd4;

   localparam logic [NODE_W-1:0] NODE_NONE = 3'd0;
   localparam logic [ROT_W-1:0]  RX_ANTENNA_NONE = 3'd6;
   localparam logic [DIGIT_W-1:0] DIGIT_LAST = 4'd9;
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);

   typedef struct packed {
      logic                run_enable;
      logic [ROLE_W-1:0]   node_role;
      logic [MASK_W-1:0]   present_mask;
      logic [TICK_W-1:0]   short_slot_us;
      logic [TICK_W-1:0]   long_slot_us;
      logic [TICK_W-1:0]   guard_slot_us;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_now;
      logic                ended_own_window;
      logic [COUNT_W-1:0]  frame_total;
      logic [DIGIT_W-1:0]  frame_digit;
      logic [COUNT_W-1:0]  element_total;
      logic [ROT_W-1:0]    antenna_pointer;
      logic [NODE_W-1:0]   tx_owner;
      logic [ROT_W-1:0]    rx_antenna;
      logic [NODE_W-1:0]   beacon_target;
      logic [NODE_W-1:0]   data_target;
      logic                own_beacon_slot;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/tss_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler configuration registers
// Write-only register file decoded from the configuration port.
// ---------------------------------------------------------------------------
module tss_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tss_pkg::cfg_type                    cfg
);
   import tss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RUN_ENABLE:    cfg_in.run_enable    = csr_wdata[0];
            CSR_NODE_ROLE:     cfg_in.node_role     = csr_wdata[ROLE_W-1:0];
            CSR_PRESENT_MASK:  cfg_in.present_mask  = csr_wdata[MASK_W-1:0];
            CSR_SHORT_SLOT_US: cfg_in.short_slot_us = csr_wdata[TICK_W-1:0];
            CSR_LONG_SLOT_US:  cfg_in.long_slot_us  = csr_wdata[TICK_W-1:0];
            CSR_GUARD_SLOT_US: cfg_in.guard_slot_us = csr_wdata[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_enable    <= 1'b0;
         cfg_ff.node_role     <= ROLE_MASTER;
         cfg_ff.present_mask  <= '0;
         cfg_ff.short_slot_us <= SHORT_SLOT_RESET;
         cfg_ff.long_slot_us  <= LONG_SLOT_RESET;
         cfg_ff.guard_slot_us <= GUARD_SLOT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: rtl/tss_sched.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler timing core
// Slot timer, frame counters, antenna rotor and per-slot schedule decode.
// ---------------------------------------------------------------------------
module tss_sched (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire tss_pkg::cfg_type cfg,
   input  wire logic      take,
   input  wire logic      advance,
   output logic           res_valid,
   output tss_pkg::rsp_type res
);
   import tss_pkg::*;

   function automatic logic in_rng(logic [SLOT_W-1:0] s, int lo, int hi);
      in_rng = (s >= SLOT_W'(lo)) && (s <= SLOT_W'(hi));
   endfunction

   function automatic logic own_window(logic [ROLE_W-1:0] role, logic [SLOT_W-1:0] s);
      unique case (role)
         ROLE_MASTER: own_window = in_rng(s, 0, 28) || s == 6'd61;
         ROLE_SLAVE1: own_window = in_rng(s, 30, 34) || s == 6'd59;
         ROLE_SLAVE2: own_window = in_rng(s, 35, 39) || s == 6'd59;
         ROLE_SLAVE3: own_window = in_rng(s, 40, 43) || s == 6'd59 || s == 6'd30;
         ROLE_SLAVE4: own_window = in_rng(s, 44, 47) || s == 6'd59 || s == 6'd35;
         default:     own_window = 1'b0;
      endcase
   endfunction

   function automatic logic [NODE_W-1:0] transmit_owner(logic [SLOT_W-1:0] s);
      if (in_rng(s, 31, 34))      transmit_owner = 3'd1;
      else if (in_rng(s, 36, 39)) transmit_owner = 3'd2;
      else if (in_rng(s, 40, 43)) transmit_owner = 3'd3;
      else if (in_rng(s, 44, 47)) transmit_owner = 3'd4;
      else                        transmit_owner = NODE_NONE;
   endfunction

   function automatic logic [ROT_W-1:0] receive_antenna(logic [SLOT_W-1:0] s);
      if (in_rng(s, 0, 6) || in_rng(s, 42, 48))        receive_antenna = 3'd0;
      else if (in_rng(s, 7, 13) || in_rng(s, 49, 55))  receive_antenna = 3'd1;
      else if (in_rng(s, 14, 20) || in_rng(s, 56, 62)) receive_antenna = 3'd2;
      else if (in_rng(s, 21, 27))                      receive_antenna = 3'd3;
      else if (in_rng(s, 28, 29))                      receive_antenna = 3'd4;
      else if (in_rng(s, 35, 41))                      receive_antenna = 3'd5;
      else                                             receive_antenna = RX_ANTENNA_NONE;
   endfunction

   function automatic logic [NODE_W-1:0] if_present(logic [NODE_W-1:0] n,
                                                    logic [MASK_W-1:0] mask);
      if_present = (n != NODE_NONE && mask[n]) ? n : NODE_NONE;
   endfunction

   // The rotor only leaves the range 0..ANTENNA_COUNT-1 for a single antenna.
   function automatic logic [ROT_W-1:0] rotor_step(logic [ROT_W-1:0] r);
      logic [ROT_W:0] sum;
      sum = {1'b0, r} + 1'b1;
      if (ANTENNA_COUNT == 1)
         rotor_step = '0;
      else if (sum >= (ROT_W+1)'(ANTENNA_COUNT))
         rotor_step = ROT_W'(sum - (ROT_W+1)'(ANTENNA_COUNT));
      else
         rotor_step = sum[ROT_W-1:0];
   endfunction

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [COUNT_W-1:0] frame_ff, frame_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [COUNT_W-1:0] element_ff, element_in;
   logic [ROT_W-1:0]   rotor_ff, rotor_in;

   logic               go;
   logic [TICK_W-1:0]  slot_len;
   logic [TICK_W:0]    tick_plus;
   logic               slot_end;
   logic               own;
   logic [NODE_W-1:0]  beacon_node;
   logic [NODE_W-1:0]  data_node;
   logic               odd;
   logic               slave_beacon;

   assign go = take && advance && cfg.run_enable && (cfg.node_role <= ROLE_SLAVE4);

   always_comb begin
      if (slot_ff == 6'd29 || slot_ff == 6'd60)
         slot_len = cfg.guard_slot_us;
      else if (in_rng(slot_ff, 30, 52) || slot_ff == 6'd59)
         slot_len = cfg.long_slot_us;
      else
         slot_len = cfg.short_slot_us;
      if (slot_len == '0)
         slot_len = TICK_W'(1);
   end

   assign tick_plus = {1'b0, tick_ff} + 1'b1;
   assign slot_end  = tick_plus >= {1'b0, slot_len};
   assign own       = own_window(cfg.node_role, slot_ff);

   always_comb begin
      slot_in    = slot_ff;
      tick_in    = tick_ff;
      frame_in   = frame_ff;
      digit_in   = digit_ff;
      element_in = element_ff;
      rotor_in   = rotor_ff;
      if (go) begin
         if (!slot_end) begin
            tick_in = tick_plus[TICK_W-1:0];
         end else begin
            tick_in = '0;
            if (cfg.node_role == ROLE_MASTER && own)
               rotor_in = rotor_step(rotor_ff);
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            if (slot_ff == SLOT_LAST) begin
               frame_in = frame_ff + 1'b1;
               digit_in = (digit_ff == DIGIT_LAST) ? '0 : digit_ff + 1'b1;
               if (digit_ff == DIGIT_LAST)
                  element_in = element_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         tick_ff    <= '0;
         frame_ff   <= '0;
         digit_ff   <= '0;
         element_ff <= '0;
         rotor_ff   <= ROT_W'(1);
      end else begin
         slot_ff    <= slot_in;
         tick_ff    <= tick_in;
         frame_ff   <= frame_in;
         digit_ff   <= digit_in;
         element_ff <= element_in;
         rotor_ff   <= rotor_in;
      end
   end

   // Beacon parity follows the frame counter after this slot end's update.
   assign odd = frame_in[0];

   always_comb begin
      beacon_node = NODE_NONE;
      if (slot_in == 6'd0)
         beacon_node = odd ? 3'd1 : 3'd3;
      else if (slot_in == 6'd5)
         beacon_node = odd ? 3'd2 : 3'd4;

      if (in_rng(slot_in, 1, 4))        data_node = 3'd1;
      else if (in_rng(slot_in, 6, 9))   data_node = 3'd2;
      else if (in_rng(slot_in, 10, 13)) data_node = 3'd3;
      else if (in_rng(slot_in, 14, 17)) data_node = 3'd4;
      else                              data_node = NODE_NONE;

      unique case (cfg.node_role)
         ROLE_SLAVE1: slave_beacon = slot_in == 6'd30 && odd;
         ROLE_SLAVE2: slave_beacon = slot_in == 6'd35 && odd;
         ROLE_SLAVE3: slave_beacon = slot_in == 6'd30 && !odd;
         ROLE_SLAVE4: slave_beacon = slot_in == 6'd35 && !odd;
         default:     slave_beacon = 1'b0;
      endcase
   end

   assign res_valid = go && slot_end;

   always_comb begin
      res.slot_now         = slot_in;
      res.ended_own_window = own;
      res.frame_total      = frame_in;
      res.frame_digit      = digit_in;
      res.element_total    = element_in;
      res.antenna_pointer  = rotor_in;
      res.tx_owner         = transmit_owner(slot_in);
      res.rx_antenna       = receive_antenna(slot_in);
      res.beacon_target    = if_present(beacon_node, cfg.present_mask);
      res.data_target      = if_present(data_node, cfg.present_mask);
      res.own_beacon_slot  = slave_beacon;
   end

endmodule
`default_nettype wire

// File: rtl/tss_rsp_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler result buffer
// Output register with one skid entry so ticks keep flowing while the
// receiver stalls, until the skid entry also holds a word.
// ---------------------------------------------------------------------------
module tss_rsp_buf (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire tss_pkg::rsp_type push_word,
   output logic             in_ready,
   output logic             out_valid,
   input  wire logic        out_ready,
   output tss_pkg::rsp_type out_word
);
   import tss_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_word_ff, out_word_in;
   rsp_type skid_word_ff, skid_word_in;
   logic    pop;

   assign pop = out_valid_ff && out_ready;

   // A push only arrives while the skid entry is free.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff) begin
         if (push) begin
            out_word_in  = push_word;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_word_in = push_word;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_word_in  = push_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule
`default_nettype wire

// File: rtl/tdma_slot_scheduler_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler
// Slot timer of a 63-slot frame for one master and four slave nodes.
// ---------------------------------------------------------------------------
// Each word on the req channel carries one microsecond tick in req_advance.
// A tick that completes a slot produces one rsp word describing the slot
// just entered; all other ticks produce nothing. The block takes one req
// word every cycle while req_ready is high; the timer state is updated and
// a result registered at the accepting edge. Registers are written through
// csr_we/csr_index/csr_wdata by the user only while the block is idle; the
// block itself does not enforce this. They take effect on the next tick.
// Reset clears the slot, tick and frame counters, sets the antenna pointer
// to one and loads the default slot lengths of 800, 2600 and 4000 ticks.
// When rsp_ready is low, one further result fits into a skid entry; once
// that entry holds a word, req_ready drops until the receiver takes the
// waiting result.
// ---------------------------------------------------------------------------
module tdma_slot_scheduler_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_advance,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [tss_pkg::SLOT_W-1:0]          rsp_slot_now,
   output logic                                rsp_ended_own_window,
   output logic [tss_pkg::COUNT_W-1:0]         rsp_frame_total,
   output logic [tss_pkg::DIGIT_W-1:0]         rsp_frame_digit,
   output logic [tss_pkg::COUNT_W-1:0]         rsp_element_total,
   output logic [tss_pkg::ROT_W-1:0]           rsp_antenna_pointer,
   output logic [tss_pkg::NODE_W-1:0]          rsp_tx_owner,
   output logic [tss_pkg::ROT_W-1:0]           rsp_rx_antenna,
   output logic [tss_pkg::NODE_W-1:0]          rsp_beacon_target,
   output logic [tss_pkg::NODE_W-1:0]          rsp_data_target,
   output logic                                rsp_own_beacon_slot,
   input  wire logic                           csr_we,
   input  wire logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tss_pkg::*;

   cfg_type cfg;
   rsp_type res;
   rsp_type rsp_word;
   logic    res_valid;
   logic    take;

   assign take = req_valid && req_ready;

   tss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tss_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .take      (take),
      .advance   (req_advance),
      .res_valid (res_valid),
      .res       (res)
   );

   tss_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

   assign rsp_slot_now         = rsp_word.slot_now;
   assign rsp_ended_own_window = rsp_word.ended_own_window;
   assign rsp_frame_total      = rsp_word.frame_total;
   assign rsp_frame_digit      = rsp_word.frame_digit;
   assign rsp_element_total    = rsp_word.element_total;
   assign rsp_antenna_pointer  = rsp_word.antenna_pointer;
   assign rsp_tx_owner         = rsp_word.tx_owner;
   assign rsp_rx_antenna       = rsp_word.rx_antenna;
   assign rsp_beacon_target    = rsp_word.beacon_target;
   assign rsp_data_target      = rsp_word.data_target;
   assign rsp_own_beacon_slot  = rsp_word.own_beacon_slot;

   // Backpressure on req only ever comes from a result waiting on rsp.
   a_stall_has_word: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no rsp word pending");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_digit <= DIGIT_LAST)
      else $error("frame digit out of decimal range");

   a_slot_rotor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot_now <= SLOT_LAST) &&
                    (rsp_antenna_pointer < ROT_W'(ANTENNA_COUNT)))
      else $error("slot index or antenna pointer out of range");

endmodule
`default_nettype wire

// File: verif/tdma_slot_scheduler_unit_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TDMA slot scheduler testbench
// Drives microsecond ticks into the slot timer and predicts every slot-end
// word from its own model of the 63-slot frame. Each returned word is
// checked field by field against the oldest prediction. The run walks
// through several schedules: disabled and undefined roles, zero and
// maximum slot lengths, a shortened slot, every role over odd and even
// frames, and a ten-frame stretch. Sender gaps and receiver stalls vary
// from phase to phase.
// ---------------------------------------------------------------------------
module tdma_slot_scheduler_unit_tb;
   import tss_pkg::*;

   class tdma_slot_tracker;
      cfg_type           cfg;
      logic [SLOT_W-1:0]  slot_index;
      logic [TICK_W-1:0]  tick_count;
      logic [COUNT_W-1:0] frames;
      logic [DIGIT_W-1:0] digit;
      logic [COUNT_W-1:0] elements;
      logic [ROT_W-1:0]   rotor;
      rsp_type            pending_slot_ends[$];
      int                 mismatches;

      function new();
         cfg.run_enable    = 1'b0;
         cfg.node_role     = ROLE_MASTER;
         cfg.present_mask  = '0;
         cfg.short_slot_us = SHORT_SLOT_RESET;
         cfg.long_slot_us  = LONG_SLOT_RESET;
         cfg.guard_slot_us = GUARD_SLOT_RESET;
         slot_index = '0;
         tick_count = '0;
         frames     = '0;
         digit      = '0;
         elements   = '0;
         rotor      = ROT_W'(1);
         mismatches = 0;
      endfunction

      function void apply_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RUN_ENABLE:    cfg.run_enable    = data[0];
            CSR_NODE_ROLE:     cfg.node_role     = data[ROLE_W-1:0];
            CSR_PRESENT_MASK:  cfg.present_mask  = data[MASK_W-1:0];
            CSR_SHORT_SLOT_US: cfg.short_slot_us = data[TICK_W-1:0];
            CSR_LONG_SLOT_US:  cfg.long_slot_us  = data[TICK_W-1:0];
            CSR_GUARD_SLOT_US: cfg.guard_slot_us = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic adv);
         int                len;
         logic [SLOT_W-1:0] old;
         logic [SLOT_W-1:0] nxt;
         logic              own;
         logic              odd;
         logic [NODE_W-1:0] node;
         rsp_type           w;
         if (!adv || !cfg.run_enable || cfg.node_role > ROLE_SLAVE4) return;
         old = slot_index;
         if (old == 29 || old == 60) len = cfg.guard_slot_us;
         else if (old inside {[30:52], 59}) len = cfg.long_slot_us;
         else len = cfg.short_slot_us;
         if (len == 0) len = 1;
         if (int'(tick_count) + 1 < len) begin
            tick_count = tick_count + 1'b1;
            return;
         end
         tick_count = '0;

         case (cfg.node_role)
            ROLE_MASTER: own = old inside {[0:28], 61};
            ROLE_SLAVE1: own = old inside {[30:34], 59};
            ROLE_SLAVE2: own = old inside {[35:39], 59};
            ROLE_SLAVE3: own = old inside {[40:43], 59, 30};
            default:     own = old inside {[44:47], 59, 35};
         endcase
         if (cfg.node_role == ROLE_MASTER && own)
            rotor = ROT_W'((int'(rotor) + 1) % ANTENNA_COUNT);

         nxt = (old == SLOT_LAST) ? '0 : old + 1'b1;
         slot_index = nxt;
         if (nxt == 0) begin
            frames = frames + 1'b1;
            digit  = (digit == DIGIT_LAST) ? '0 : digit + 1'b1;
            if (digit == 0) elements = elements + 1'b1;
         end
         odd = frames[0];

         w.slot_now         = nxt;
         w.ended_own_window = own;
         w.frame_total      = frames;
         w.frame_digit      = digit;
         w.element_total    = elements;
         w.antenna_pointer  = rotor;

         if (nxt inside {[31:34]}) w.tx_owner = ROLE_SLAVE1;
         else if (nxt inside {[36:39]}) w.tx_owner = ROLE_SLAVE2;
         else if (nxt inside {[40:43]}) w.tx_owner = ROLE_SLAVE3;
         else if (nxt inside {[44:47]}) w.tx_owner = ROLE_SLAVE4;
         else w.tx_owner = NODE_NONE;

         if (nxt inside {[0:6], [42:48]}) w.rx_antenna = 3'd0;
         else if (nxt inside {[7:13], [49:55]}) w.rx_antenna = 3'd1;
         else if (nxt inside {[14:20], [56:62]}) w.rx_antenna = 3'd2;
         else if (nxt inside {[21:27]}) w.rx_antenna = 3'd3;
         else if (nxt inside {[28:29]}) w.rx_antenna = 3'd4;
         else if (nxt inside {[35:41]}) w.rx_antenna = 3'd5;
         else w.rx_antenna = RX_ANTENNA_NONE;

         // The beacon goes out only when the addressed slave is present.
         if (nxt == 0) node = odd ? ROLE_SLAVE1 : ROLE_SLAVE3;
         else if (nxt == 5) node = odd ? ROLE_SLAVE2 : ROLE_SLAVE4;
         else node = NODE_NONE;
         w.beacon_target = (node != NODE_NONE && cfg.present_mask[node]) ? node : NODE_NONE;

         if (nxt inside {[1:4]}) node = ROLE_SLAVE1;
         else if (nxt inside {[6:9]}) node = ROLE_SLAVE2;
         else if (nxt inside {[10:13]}) node = ROLE_SLAVE3;
         else if (nxt inside {[14:17]}) node = ROLE_SLAVE4;
         else node = NODE_NONE;
         w.data_target = (node != NODE_NONE && cfg.present_mask[node]) ? node : NODE_NONE;

         case (cfg.node_role)
            ROLE_SLAVE1: w.own_beacon_slot = (nxt == 30) && odd;
            ROLE_SLAVE2: w.own_beacon_slot = (nxt == 35) && odd;
            ROLE_SLAVE3: w.own_beacon_slot = (nxt == 30) && !odd;
            ROLE_SLAVE4: w.own_beacon_slot = (nxt == 35) && !odd;
            default:     w.own_beacon_slot = 1'b0;
         endcase
         pending_slot_ends.push_back(w);
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endfunction

      function void compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
      endfunction

      function void check_slot_end(rsp_type got);
         rsp_type want;
         if (pending_slot_ends.size() == 0) begin
            report($sformatf("unexpected word for slot %0d", got.slot_now));
            return;
         end
         want = pending_slot_ends.pop_front();
         compare_field("slot_now", 32'(got.slot_now), 32'(want.slot_now));
         compare_field("ended_own_window", 32'(got.ended_own_window),
                       32'(want.ended_own_window));
         compare_field("frame_total", got.frame_total, want.frame_total);
         compare_field("frame_digit", 32'(got.frame_digit), 32'(want.frame_digit));
         compare_field("element_total", got.element_total, want.element_total);
         compare_field("antenna_pointer", 32'(got.antenna_pointer),
                       32'(want.antenna_pointer));
         compare_field("tx_owner", 32'(got.tx_owner), 32'(want.tx_owner));
         compare_field("rx_antenna", 32'(got.rx_antenna), 32'(want.rx_antenna));
         compare_field("beacon_target", 32'(got.beacon_target), 32'(want.beacon_target));
         compare_field("data_target", 32'(got.data_target), 32'(want.data_target));
         compare_field("own_beacon_slot", 32'(got.own_beacon_slot),
                       32'(want.own_beacon_slot));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_advance = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SLOT_W-1:0]      rsp_slot_now;
   logic                   rsp_ended_own_window;
   logic [COUNT_W-1:0]     rsp_frame_total;
   logic [DIGIT_W-1:0]     rsp_frame_digit;
   logic [COUNT_W-1:0]     rsp_element_total;
   logic [ROT_W-1:0]       rsp_antenna_pointer;
   logic [NODE_W-1:0]      rsp_tx_owner;
   logic [ROT_W-1:0]       rsp_rx_antenna;
   logic [NODE_W-1:0]      rsp_beacon_target;
   logic [NODE_W-1:0]      rsp_data_target;
   logic                   rsp_own_beacon_slot;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   tdma_slot_tracker tracker = new();

   tdma_slot_scheduler_unit u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.slot_now         = rsp_slot_now;
         got.ended_own_window = rsp_ended_own_window;
         got.frame_total      = rsp_frame_total;
         got.frame_digit      = rsp_frame_digit;
         got.element_total    = rsp_element_total;
         got.antenna_pointer  = rsp_antenna_pointer;
         got.tx_owner         = rsp_tx_owner;
         got.rx_antenna       = rsp_rx_antenna;
         got.beacon_target    = rsp_beacon_target;
         got.data_target      = rsp_data_target;
         got.own_beacon_slot  = rsp_own_beacon_slot;
         tracker.check_slot_end(got);
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Valid stays high between back-to-back words; it only drops for a gap.
   task send_tick(input logic adv);
      req_valid   <= 1'b1;
      req_advance <= adv;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(adv);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   task run_ticks(input int count, input int adv_pct);
      for (int i = 0; i < count; i++)
         send_tick($urandom_range(99) < adv_pct);
   endtask

   // Wait until every slot end has come back, then wait on for ticks still
   // in flight that produce no word.
   task settle();
      req_valid <= 1'b0;
      while (tracker.pending_slot_ends.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task load_schedule(input logic en, input logic [ROLE_W-1:0] role,
                      input logic [MASK_W-1:0] mask, input logic [TICK_W-1:0] s_len,
                      input logic [TICK_W-1:0] l_len, input logic [TICK_W-1:0] g_len,
                      input logic junk);
      logic [CSR_DATA_W-1:0] vals [CSR_RUN_ENABLE:CSR_GUARD_SLOT_US];
      logic [CSR_DATA_W-1:0] noise;
      noise = junk ? CSR_DATA_W'($urandom) : '0;
      vals[CSR_RUN_ENABLE]    = {noise[CSR_DATA_W-1:1], en};
      vals[CSR_NODE_ROLE]     = {noise[CSR_DATA_W-1:ROLE_W], role};
      vals[CSR_PRESENT_MASK]  = {noise[CSR_DATA_W-1:MASK_W], mask};
      vals[CSR_SHORT_SLOT_US] = s_len;
      vals[CSR_LONG_SLOT_US]  = l_len;
      vals[CSR_GUARD_SLOT_US] = g_len;
      csr_we <= 1'b1;
      for (int i = CSR_RUN_ENABLE; i <= CSR_GUARD_SLOT_US; i++) begin
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         tracker.apply_config(CSR_IDX_W'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task set_idling(input int phase);
      case (phase % 4)
         0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         1: begin tx_idle_pct = 69; rx_idle_pct = 0;  end
         2: begin tx_idle_pct = 0;  rx_idle_pct = 69; end
         default: begin tx_idle_pct = 27; rx_idle_pct = 27; end
      endcase
   endtask

   function automatic logic [TICK_W-1:0] random_length();
      case ($urandom_range(9))
         0:       return '0;
         1:       return TICK_W'($urandom_range(6, 40));
         default: return TICK_W'($urandom_range(1, 5));
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset leaves the schedule disabled, so these ticks do nothing.
      run_ticks(2, 100);
      settle();
      load_schedule(1'b1, 3'd7, 5'd31, '0, '0, '0, 1'b0);
      run_ticks(2, 100);
      settle();
      // Zero lengths count as one tick, so every tick ends a slot.
      load_schedule(1'b1, ROLE_MASTER, 5'd31, '0, '0, '0, 1'b0);
      send_tick(1'b0);
      run_ticks(4, 100);
      settle();
      // Count part way into a long slot, then shorten it below the count.
      load_schedule(1'b1, ROLE_MASTER, 5'd31, 12'd4095, 12'd4095, 12'd4095, 1'b0);
      run_ticks(6, 100);
      settle();
      load_schedule(1'b1, ROLE_MASTER, 5'd10, 12'd2, 12'd2, 12'd2, 1'b0);
      run_ticks(3, 100);
      settle();

      for (int p = 0; p < 8; p++) begin
         set_idling(p);
         load_schedule($urandom_range(9) != 0,
                       ($urandom_range(7) == 0) ? ROLE_W'($urandom_range(5, 7))
                                                : ROLE_W'($urandom_range(4)),
                       MASK_W'($urandom_range(31)),
                       random_length(), random_length(), random_length(), 1'b1);
         run_ticks(20, 85);
         settle();
      end

      // Two frames per role cover odd and even frame beacons. Together the
      // roles span more than ten frames, which rolls the decimal digit and
      // bumps the element count.
      for (int r = ROLE_MASTER; r <= ROLE_SLAVE4; r++) begin
         set_idling(r);
         load_schedule(1'b1, ROLE_W'(r), MASK_W'($urandom_range(31)),
                       12'd1, 12'd1, '0, 1'b0);
         run_ticks(130, 100);
         settle();
      end

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      settle();
      if (tracker.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
